// ===== rtl/frame_digest_desync_checker_top_assert.svh =====
// Assertion macros for the frame digest desync checker top level.
// Included by frame_digest_desync_checker_top.sv; no other dependencies.
`ifndef FRAME_DIGEST_DESYNC_CHECKER_TOP_ASSERT_SVH
`define FRAME_DIGEST_DESYNC_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdc assertion failed");

// next-cycle implication, disabled while in reset
`define FDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdc assertion failed");

`endif

// ===== rtl/fdc_pkg.sv =====
// Shared types and constants for the frame digest desync checker.
// Used by fdc_cell and frame_digest_desync_checker_top.
package fdc_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int FRAME_BITS_DEF = 32;

  localparam int DIGEST_W   = 64;
  localparam int DEPTH_W    = 32;
  localparam int WINDOW_W   = 32;
  localparam int CMP_CNT_W  = 16;
  localparam int CAP_REG_W  = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_STORE    = 2'd0,
    KIND_VALIDATE = 2'd1,
    KIND_QUERY    = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic cmp;
    logic wr_hit;
    logic ins;
    logic evict;
  } fdc_ctl_t;

endpackage

// ===== rtl/frame_digest_desync_checker_top.sv =====
// Channel   Dir  Handshake             Payload
// in_       in   in_valid/in_ready     kind, frame, digest, batch_start
// out_      out  out_valid/out_ready   found .. latest_frame (9 fields)
// cfg_      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// An item passes through accept, per-cell compare, OR reduction and update.
// A store that overflows the table then shifts out the oldest entry in idle;
// lowering the capacity evicts entries one at a time, with in_ready low.
// Reset clears count, latest frame, diagnostics and window, sets the default capacity; no clearing pass.
// A waiting result does not block the next accept; that item then holds in the
// update stage, in_ready low, until the waiting beat is taken.
//
// Top level of the frame digest desync checker. Depends on fdc_pkg, fdc_cell
// and the assertion macro header.
module frame_digest_desync_checker_top #(
  parameter int CAPACITY   = fdc_pkg::CAPACITY_DEF,
  parameter int FRAME_BITS = fdc_pkg::FRAME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic signed [FRAME_BITS-1:0]       in_frame,
  input  logic [fdc_pkg::DIGEST_W-1:0]       in_digest,
  input  logic                               in_batch_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic                               out_digest_match,
  output logic [fdc_pkg::DEPTH_W-1:0]        out_prediction_depth,
  output logic                               out_prediction_allowed,
  output logic                               out_desync_detected,
  output logic signed [FRAME_BITS-1:0]       out_first_divergent_frame,
  output logic [fdc_pkg::CMP_CNT_W-1:0]      out_compared_count,
  output logic                               out_latest_valid,
  output logic signed [FRAME_BITS-1:0]       out_latest_frame,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  `include "frame_digest_desync_checker_top_assert.svh"

  localparam int DEPTH = CAPACITY + 1;  // one spare cell for the overflowing insert
  localparam int CNT_W = $clog2(CAPACITY + 2);
  localparam int SW    = (FRAME_BITS + 1 > fdc_pkg::DEPTH_W) ? FRAME_BITS + 1
                                                            : fdc_pkg::DEPTH_W + 1;
  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((CAPACITY < 64) ? CAPACITY : 64);
  localparam logic signed [FRAME_BITS-1:0] FRAME_MIN = {1'b1, {(FRAME_BITS-1){1'b0}}};
  localparam logic [fdc_pkg::CMP_CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_UPD} state_t;

  state_t                             st_r;
  fdc_pkg::kind_t                     kind_r;
  logic signed [FRAME_BITS-1:0]       frame_r;
  logic [fdc_pkg::DIGEST_W-1:0]       digest_r;
  logic                               batch_r;
  logic [CNT_W-1:0]                   count_r;
  logic [CNT_W-1:0]                   cap_r;
  logic [fdc_pkg::WINDOW_W-1:0]       win_r;
  logic                               lk_r;
  logic signed [FRAME_BITS-1:0]       latest_r;
  logic                               desync_r;
  logic signed [FRAME_BITS-1:0]       div_r;
  logic [fdc_pkg::CMP_CNT_W-1:0]      cmp_cnt_r;
  logic                               found_r;
  logic                               match_r;

  logic                               out_valid_r;
  logic                               out_found_r;
  logic                               out_match_r;
  logic [fdc_pkg::DEPTH_W-1:0]        out_depth_r;
  logic                               out_allowed_r;

  fdc_pkg::fdc_ctl_t                  ctl;
  logic signed [FRAME_BITS-1:0]       cell_frame  [DEPTH];
  logic [fdc_pkg::DIGEST_W-1:0]       cell_digest [DEPTH];
  logic [DEPTH-1:0]                   lt_vec, hit_vec, dm_vec, occ_vec;

  logic                               evict_need, upd_go;
  logic                               is_store, is_val, is_clr, diag_clr;
  logic                               d_flag;
  logic signed [FRAME_BITS-1:0]       d_div;
  logic [fdc_pkg::CMP_CNT_W-1:0]      d_cnt;
  logic                               lk_nxt, desync_nxt;
  logic signed [FRAME_BITS-1:0]       latest_nxt, div_nxt;
  logic [fdc_pkg::CMP_CNT_W-1:0]      cmp_cnt_nxt;
  logic [CNT_W-1:0]                   count_nxt;
  logic [SW-1:0]                      diff;
  logic [fdc_pkg::DEPTH_W-1:0]        depth_nxt;
  logic [31:0]                        cap_req;
  logic [CNT_W-1:0]                   cap_nxt;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          p_lt;
    logic signed [FRAME_BITS-1:0]  p_frame, n_frame;
    logic [fdc_pkg::DIGEST_W-1:0]  p_digest, n_digest;

    if (i == 0) begin : g_first
      assign p_lt     = 1'b1;
      assign p_frame  = '0;
      assign p_digest = '0;
    end else begin : g_mid
      assign p_lt     = lt_vec[i-1];
      assign p_frame  = cell_frame[i-1];
      assign p_digest = cell_digest[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_frame  = '0;
      assign n_digest = '0;
    end else begin : g_inner
      assign n_frame  = cell_frame[i+1];
      assign n_digest = cell_digest[i+1];
    end

    assign occ_vec[i] = (CNT_W'(i) < count_r);

    fdc_cell #(.FRAME_BITS(FRAME_BITS)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ_vec[i]),
      .key_frame   (frame_r),
      .key_digest  (digest_r),
      .prev_lt     (p_lt),
      .prev_frame  (p_frame),
      .prev_digest (p_digest),
      .next_frame  (n_frame),
      .next_digest (n_digest),
      .frame_o     (cell_frame[i]),
      .digest_o    (cell_digest[i]),
      .lt_o        (lt_vec[i]),
      .hit_o       (hit_vec[i]),
      .dm_o        (dm_vec[i])
    );
  end

  // ---------------- control ----------------
  assign evict_need = (count_r > cap_r);
  assign in_ready   = (st_r == S_IDLE) && !evict_need;
  assign cfg_ready  = 1'b1;
  assign upd_go     = (st_r == S_UPD) && (!out_valid_r || out_ready);

  assign is_store = (kind_r == fdc_pkg::KIND_STORE);
  assign is_val   = (kind_r == fdc_pkg::KIND_VALIDATE);
  assign is_clr   = (kind_r == fdc_pkg::KIND_CLEAR);

  always_comb begin
    ctl.cmp    = (st_r == S_CMP);
    ctl.wr_hit = upd_go && is_store && found_r;
    ctl.ins    = upd_go && is_store && !found_r;
    ctl.evict  = (st_r == S_IDLE) && evict_need;
  end

  // update-stage next state
  always_comb begin
    diag_clr = is_clr || (is_val && batch_r);
    d_flag   = diag_clr ? 1'b0 : desync_r;
    d_div    = diag_clr ? FRAME_MIN : div_r;
    d_cnt    = diag_clr ? '0 : cmp_cnt_r;

    lk_nxt      = lk_r;
    latest_nxt  = latest_r;
    desync_nxt  = d_flag;
    div_nxt     = d_div;
    cmp_cnt_nxt = d_cnt;
    count_nxt   = count_r;

    if (is_clr) begin
      lk_nxt     = 1'b0;
      latest_nxt = FRAME_MIN;
      count_nxt  = '0;
    end else if (is_store && !found_r) begin
      count_nxt = count_r + 1'b1;
    end else if (is_val && found_r) begin
      // the minimum frame is compared but never becomes the latest frame
      if (frame_r != FRAME_MIN && (!lk_r || frame_r > latest_r)) begin
        lk_nxt     = 1'b1;
        latest_nxt = frame_r;
      end
      if (d_cnt != CNT_MAX) begin
        cmp_cnt_nxt = d_cnt + 1'b1;
      end
      if (!match_r && !d_flag) begin
        desync_nxt = 1'b1;
        div_nxt    = frame_r;
      end
    end

    diff = SW'(frame_r) - SW'(latest_nxt);
    if (lk_nxt && frame_r > latest_nxt) begin
      depth_nxt = (|diff[SW-1:fdc_pkg::DEPTH_W]) ? '1 : diff[fdc_pkg::DEPTH_W-1:0];
    end else begin
      depth_nxt = '0;
    end
  end

  // capacity request: zero means one, clamp to the built table size
  always_comb begin
    cap_req = {{(32 - fdc_pkg::CAP_REG_W){1'b0}}, cfg_data[fdc_pkg::CAP_REG_W-1:0]};
    if (cap_req == 32'd0) begin
      cap_req = 32'd1;
    end
    if (cap_req > 32'(CAPACITY)) begin
      cap_req = 32'(CAPACITY);
    end
    cap_nxt = cap_req[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RST;
      win_r       <= '0;
      lk_r        <= 1'b0;
      latest_r    <= FRAME_MIN;
      desync_r    <= 1'b0;
      div_r       <= FRAME_MIN;
      cmp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fdc_pkg::REG_CAPACITY) begin
          cap_r <= cap_nxt;
        end else if (cfg_index == fdc_pkg::REG_WINDOW) begin
          win_r <= cfg_data[fdc_pkg::WINDOW_W-1:0];
        end
      end

      if (out_valid_r && out_ready && !upd_go) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_IDLE: begin
          if (evict_need) begin
            count_r <= count_r - 1'b1;
          end else if (in_valid) begin
            kind_r   <= fdc_pkg::kind_t'(in_kind);
            frame_r  <= in_frame;
            digest_r <= in_digest;
            batch_r  <= in_batch_start;
            st_r     <= S_CMP;
          end
        end
        S_CMP: begin
          st_r <= S_RED;
        end
        S_RED: begin
          found_r <= |hit_vec;
          match_r <= |(hit_vec & dm_vec);
          st_r    <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            lk_r          <= lk_nxt;
            latest_r      <= latest_nxt;
            desync_r      <= desync_nxt;
            div_r         <= div_nxt;
            cmp_cnt_r     <= cmp_cnt_nxt;
            count_r       <= count_nxt;
            out_valid_r   <= 1'b1;
            out_found_r   <= !is_clr && found_r;
            out_match_r   <= !is_clr && match_r;
            out_depth_r   <= depth_nxt;
            out_allowed_r <= !lk_nxt || (depth_nxt <= win_r);
            st_r          <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_found                 = out_found_r;
  assign out_digest_match          = out_match_r;
  assign out_prediction_depth      = out_depth_r;
  assign out_prediction_allowed    = out_allowed_r;
  assign out_desync_detected       = desync_r;
  assign out_first_divergent_frame = div_r;
  assign out_compared_count        = cmp_cnt_r;
  assign out_latest_valid          = lk_r;
  assign out_latest_frame          = latest_r;

  // ---------------- assertions ----------------
  `FDC_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `FDC_ASSERT_NOW(a_no_accept_over_cap, clk, rst_n, in_valid && in_ready, count_r <= cap_r)
  `FDC_ASSERT_NEXT(a_stall_holds_update, clk, rst_n,
                   st_r == S_UPD && out_valid_r && !out_ready,
                   st_r == S_UPD && out_valid_r)
  `FDC_ASSERT_NEXT(a_evict_step, clk, rst_n, st_r == S_IDLE && evict_need,
                   count_r == $past(count_r) - 1'b1)

endmodule

// ===== rtl/fdc_cell.sv =====
// One slot of the sorted digest chain: holds a frame and its digest.
// Depends on fdc_pkg; shifts with its neighbors on insert and evict.
module fdc_cell #(
  parameter int FRAME_BITS = fdc_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk,
  input  fdc_pkg::fdc_ctl_t                   ctl,
  input  logic                                occ,
  input  logic signed [FRAME_BITS-1:0]        key_frame,
  input  logic [fdc_pkg::DIGEST_W-1:0]        key_digest,
  input  logic                                prev_lt,
  input  logic signed [FRAME_BITS-1:0]        prev_frame,
  input  logic [fdc_pkg::DIGEST_W-1:0]        prev_digest,
  input  logic signed [FRAME_BITS-1:0]        next_frame,
  input  logic [fdc_pkg::DIGEST_W-1:0]        next_digest,
  output logic signed [FRAME_BITS-1:0]        frame_o,
  output logic [fdc_pkg::DIGEST_W-1:0]        digest_o,
  output logic                                lt_o,
  output logic                                hit_o,
  output logic                                dm_o
);

  logic signed [FRAME_BITS-1:0]  frame_r;
  logic [fdc_pkg::DIGEST_W-1:0]  digest_r;
  logic                          lt_r;
  logic                          hit_r;
  logic                          dm_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit_r <= occ && (frame_r == key_frame);
      lt_r  <= occ && (frame_r < key_frame);
      dm_r  <= (digest_r == key_digest);
    end
    if (ctl.evict) begin
      frame_r  <= next_frame;
      digest_r <= next_digest;
    end else if (ctl.ins) begin
      // cells holding older frames stay; the first newer one takes the key
      if (!lt_r) begin
        if (prev_lt) begin
          frame_r  <= key_frame;
          digest_r <= key_digest;
        end else begin
          frame_r  <= prev_frame;
          digest_r <= prev_digest;
        end
      end
    end else if (ctl.wr_hit && hit_r) begin
      digest_r <= key_digest;
    end
  end

  assign frame_o  = frame_r;
  assign digest_o = digest_r;
  assign lt_o     = lt_r;
  assign hit_o    = hit_r;
  assign dm_o     = dm_r;

endmodule

// ===== verif/tb.sv =====
// Testbench for frame_digest_desync_checker_top: directed and random digest traffic
// checked beat by beat against an in-bench predictor of the digest table.
// Depends on fdc_pkg and the top-level RTL only.
module tb;

  localparam int FRAME_W      = fdc_pkg::FRAME_BITS_DEF;
  localparam int TBL_CAP      = fdc_pkg::CAPACITY_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 250000;

  typedef logic signed [FRAME_W-1:0] frame_t;

  localparam frame_t FRAME_NONE  = {1'b1, {(FRAME_W-1){1'b0}}};
  localparam frame_t FRAME_FLOOR = FRAME_NONE + 1;
  localparam frame_t FRAME_MAX   = {1'b0, {(FRAME_W-1){1'b1}}};

  typedef struct packed {
    logic                          found;
    logic                          digest_match;
    logic [fdc_pkg::DEPTH_W-1:0]   depth;
    logic                          allowed;
    logic                          desync;
    frame_t                        div_frame;
    logic [fdc_pkg::CMP_CNT_W-1:0] compared;
    logic                          latest_valid;
    frame_t                        latest_frame;
  } digest_verdict_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_kind = fdc_pkg::KIND_QUERY;
  frame_t                         in_frame = '0;
  logic [fdc_pkg::DIGEST_W-1:0]   in_digest = '0;
  logic                           in_batch_start = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_found;
  logic                           out_digest_match;
  logic [fdc_pkg::DEPTH_W-1:0]    out_prediction_depth;
  logic                           out_prediction_allowed;
  logic                           out_desync_detected;
  frame_t                         out_first_divergent_frame;
  logic [fdc_pkg::CMP_CNT_W-1:0]  out_compared_count;
  logic                           out_latest_valid;
  frame_t                         out_latest_frame;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fdc_pkg::CFG_IDX_W-1:0]  cfg_index = fdc_pkg::REG_CAPACITY;
  logic [fdc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  frame_digest_desync_checker_top dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_kind                   (in_kind),
    .in_frame                  (in_frame),
    .in_digest                 (in_digest),
    .in_batch_start            (in_batch_start),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_found                 (out_found),
    .out_digest_match          (out_digest_match),
    .out_prediction_depth      (out_prediction_depth),
    .out_prediction_allowed    (out_prediction_allowed),
    .out_desync_detected       (out_desync_detected),
    .out_first_divergent_frame (out_first_divergent_frame),
    .out_compared_count        (out_compared_count),
    .out_latest_valid          (out_latest_valid),
    .out_latest_frame          (out_latest_frame),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: one spare slot holds an insert before the oldest is dropped
  frame_t                       tbl_frame  [0:TBL_CAP];
  logic [fdc_pkg::DIGEST_W-1:0] tbl_digest [0:TBL_CAP];
  int                           tbl_count  = 0;
  bit                           auth_known = 1'b0;
  frame_t                       auth_frame = FRAME_NONE;
  bit                           desync_q   = 1'b0;
  frame_t                       diverge_q  = FRAME_NONE;
  int unsigned                  cmp_q      = 0;
  int                           cap_q      = (TBL_CAP < 64) ? TBL_CAP : 64;
  logic [fdc_pkg::WINDOW_W-1:0] window_q   = '0;

  digest_verdict_t verdict_q[$];
  int mismatch_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int stall_run = 0;
  bit ready_hold = 1'b1;

  function automatic void drop_oldest_excess();
    while (tbl_count > cap_q) begin
      for (int i = 1; i < tbl_count; i++) begin
        tbl_frame[i-1]  = tbl_frame[i];
        tbl_digest[i-1] = tbl_digest[i];
      end
      tbl_count--;
    end
  endfunction

  function automatic void wipe_diagnostics();
    desync_q  = 1'b0;
    diverge_q = FRAME_NONE;
    cmp_q     = 0;
  endfunction

  function automatic void apply_reg(logic [fdc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fdc_pkg::CFG_DATA_W-1:0] word);
    int c;
    if (idx == fdc_pkg::REG_CAPACITY) begin
      c = int'(word[fdc_pkg::CAP_REG_W-1:0]);
      if (c < 1) c = 1;
      if (c > TBL_CAP) c = TBL_CAP;
      cap_q = c;
      drop_oldest_excess();
    end else if (idx == fdc_pkg::REG_WINDOW) begin
      window_q = word[fdc_pkg::WINDOW_W-1:0];
    end
  endfunction

  function automatic digest_verdict_t predict_verdict(fdc_pkg::kind_t k, frame_t f,
                                                      logic [fdc_pkg::DIGEST_W-1:0] dg,
                                                      logic bs);
    digest_verdict_t v;
    int pos;
    int p;
    longint ahead;
    v = '0;
    pos = -1;
    if (k == fdc_pkg::KIND_CLEAR) begin
      tbl_count  = 0;
      auth_known = 1'b0;
      auth_frame = FRAME_NONE;
      wipe_diagnostics();
    end else begin
      if (k == fdc_pkg::KIND_VALIDATE && bs) wipe_diagnostics();
      for (int i = 0; i < tbl_count; i++)
        if (pos < 0 && tbl_frame[i] == f) pos = i;
      if (pos >= 0) begin
        v.found = 1'b1;
        v.digest_match = (tbl_digest[pos] == dg);
      end
      if (k == fdc_pkg::KIND_STORE) begin
        if (pos >= 0) begin
          tbl_digest[pos] = dg;
        end else begin
          p = 0;
          while (p < tbl_count && tbl_frame[p] < f) p++;
          for (int i = tbl_count; i > p; i--) begin
            tbl_frame[i]  = tbl_frame[i-1];
            tbl_digest[i] = tbl_digest[i-1];
          end
          tbl_frame[p]  = f;
          tbl_digest[p] = dg;
          tbl_count++;
          drop_oldest_excess();
        end
      end else if (k == fdc_pkg::KIND_VALIDATE && v.found) begin
        // the minimum frame stands for "none" and never becomes the latest
        if (f != FRAME_NONE && (!auth_known || f > auth_frame)) begin
          auth_frame = f;
          auth_known = 1'b1;
        end
        if (cmp_q < 32'hFFFF) cmp_q++;
        if (!v.digest_match && !desync_q) begin
          desync_q  = 1'b1;
          diverge_q = f;
        end
      end
    end
    if (auth_known && f > auth_frame) begin
      ahead = longint'(f) - longint'(auth_frame);
      v.depth = (ahead > 64'sh0_FFFF_FFFF) ? '1 : ahead[fdc_pkg::DEPTH_W-1:0];
    end
    v.allowed      = !auth_known || (v.depth <= window_q);
    v.desync       = desync_q;
    v.div_frame    = diverge_q;
    v.compared     = cmp_q[fdc_pkg::CMP_CNT_W-1:0];
    v.latest_valid = auth_known;
    v.latest_frame = auth_frame;
    return v;
  endfunction

  function automatic void note_field(string fname, logic signed [63:0] want_v,
                                     logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", fname, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    digest_verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no expected result waiting");
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        results_checked++;
        note_field("found", want.found, out_found);
        note_field("digest_match", want.digest_match, out_digest_match);
        note_field("prediction_depth", want.depth, out_prediction_depth);
        note_field("prediction_allowed", want.allowed, out_prediction_allowed);
        note_field("desync_detected", want.desync, out_desync_detected);
        note_field("first_divergent_frame", want.div_frame, out_first_divergent_frame);
        note_field("compared_count", want.compared, out_compared_count);
        note_field("latest_valid", want.latest_valid, out_latest_valid);
        note_field("latest_frame", want.latest_frame, out_latest_frame);
      end
    end
  end

  // receiver back-pressure: mode follows bits 10:9 of the cycle counter
  always @(posedge clk) begin
    case (cycle_count[10:9])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run == 0) begin
          ready_hold = !ready_hold;
          stall_run = $urandom_range(1, 12);
        end else begin
          stall_run--;
        end
        out_ready <= ready_hold;
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout with %0d results outstanding", verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one input beat; valid stays up inside a burst, drops for a gap at its end
  task automatic send_item(input fdc_pkg::kind_t k, input frame_t f,
                           input logic [fdc_pkg::DIGEST_W-1:0] dg, input logic bs);
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_frame       <= f;
    in_digest      <= dg;
    in_batch_start <= bs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict_q.insert(verdict_q.size(), predict_verdict(k, f, dg, bs));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers back to back, block drained first
  task automatic program_regs(input logic [fdc_pkg::CFG_DATA_W-1:0] cap_word,
                              input logic [fdc_pkg::CFG_DATA_W-1:0] win_word);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= fdc_pkg::REG_CAPACITY;
    cfg_data  <= cap_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(fdc_pkg::REG_CAPACITY, cap_word);
    cfg_index <= fdc_pkg::REG_WINDOW;
    cfg_data  <= win_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(fdc_pkg::REG_WINDOW, win_word);
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  task automatic test_directed_lookup();
    send_item(fdc_pkg::KIND_QUERY, 100, '0, 1'b1);
    send_item(fdc_pkg::KIND_STORE, 10, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_item(fdc_pkg::KIND_STORE, 10, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_item(fdc_pkg::KIND_STORE, 5, 64'h5555_AAAA_5555_AAAA, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, 10, 64'hFEDC_BA98_7654_3210, 1'b1);
    send_item(fdc_pkg::KIND_VALIDATE, 5, 64'hAAAA_5555_AAAA_5555, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, 7, 64'hFEDC_BA98_7654_3210, 1'b0);
    // second mismatch must not move the divergent frame
    send_item(fdc_pkg::KIND_VALIDATE, 10, '0, 1'b0);
    send_item(fdc_pkg::KIND_QUERY, FRAME_MAX, '0, 1'b0);
    send_item(fdc_pkg::KIND_QUERY, 3, '0, 1'b0);
    send_item(fdc_pkg::KIND_STORE, FRAME_NONE, '1, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, FRAME_NONE, '1, 1'b1);
    send_item(fdc_pkg::KIND_STORE, 11, 64'h1, 1'b1);
    send_item(fdc_pkg::KIND_CLEAR, 11, '1, 1'b1);
    send_item(fdc_pkg::KIND_VALIDATE, 10, 64'hFEDC_BA98_7654_3210, 1'b0);
    wait_for_results();
  endtask

  task automatic test_capacity_limits();
    program_regs(2, 32'hFFFF_FFFF);
    send_item(fdc_pkg::KIND_STORE, FRAME_FLOOR, '0, 1'b0);
    send_item(fdc_pkg::KIND_STORE, FRAME_MAX, '1, 1'b0);
    send_item(fdc_pkg::KIND_STORE, 0, 64'h8000_0000_0000_0001, 1'b0);
    // older than everything while full: dropped right away
    send_item(fdc_pkg::KIND_STORE, -5, 64'h77, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, -5, 64'h77, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, FRAME_MAX, '1, 1'b0);
    send_item(fdc_pkg::KIND_QUERY, 0, '0, 1'b0);
    // shrinking with two entries held evicts the older one
    program_regs(1, 0);
    send_item(fdc_pkg::KIND_VALIDATE, 0, 64'h8000_0000_0000_0001, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, FRAME_MAX, '1, 1'b0);
    program_regs(32'h80, 5);
    send_item(fdc_pkg::KIND_STORE, 1, 64'h11, 1'b0);
    send_item(fdc_pkg::KIND_STORE, 2, 64'h22, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, 1, 64'h11, 1'b0);
    program_regs(32'h7F, 0);
    send_item(fdc_pkg::KIND_STORE, 1, 64'h11, 1'b0);
    send_item(fdc_pkg::KIND_VALIDATE, 2, 64'h22, 1'b0);
    wait_for_results();
  endtask

  task automatic test_prediction_sessions();
    frame_t                         next_f;
    frame_t                         f;
    frame_t                         held_f[$];
    logic [fdc_pkg::DIGEST_W-1:0]   held_d[$];
    logic [fdc_pkg::DIGEST_W-1:0]   dg;
    logic [fdc_pkg::CFG_DATA_W-1:0] cap_word;
    logic [fdc_pkg::CFG_DATA_W-1:0] win_word;
    int roll;
    int idx;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cap_word = 64; win_word = 0; end
        1: begin cap_word = 1; win_word = 32'hFFFF_FFFF; end
        2: begin cap_word = 2; win_word = 3; end
        3: begin cap_word = $urandom_range(3, 16); win_word = $urandom_range(0, 40); end
        4: begin cap_word = 32'h7F; win_word = $urandom_range(0, 40); end
        5: begin cap_word = $urandom_range(1, 64); win_word = $urandom; end
        6: begin cap_word = 32'hFFFF_FF80; win_word = 8; end
        default: begin cap_word = 64; win_word = $urandom_range(0, 40); end
      endcase
      program_regs(cap_word, win_word);
      if ($urandom_range(0, 1) == 0)
        send_item(fdc_pkg::KIND_CLEAR, frame_t'($urandom), '0, 1'b0);
      next_f = frame_t'($urandom);
      held_f.delete();
      held_d.delete();
      for (int n = 0; n < 125; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 38 || held_f.size() == 0) begin
          next_f = next_f + frame_t'($urandom_range(1, 3));
          dg = {$urandom, $urandom};
          send_item(fdc_pkg::KIND_STORE, next_f, dg, $urandom_range(0, 9) == 0);
          held_f.insert(held_f.size(), next_f);
          held_d.insert(held_d.size(), dg);
          if (held_f.size() > 80) begin
            void'(held_f.pop_front());
            void'(held_d.pop_front());
          end
        end else if (roll < 46) begin
          // re-prediction after a rollback
          idx = $urandom_range(0, held_f.size() - 1);
          held_d[idx] = {$urandom, $urandom};
          send_item(fdc_pkg::KIND_STORE, held_f[idx], held_d[idx], 1'b0);
        end else if (roll < 50) begin
          send_item(fdc_pkg::KIND_STORE, held_f[0] - frame_t'($urandom_range(1, 50)),
                    {$urandom, $urandom}, 1'b0);
        end else if (roll < 80) begin
          idx = $urandom_range(0, held_f.size() - 1);
          dg = held_d[idx];
          if ($urandom_range(0, 9) == 0) dg = dg ^ (64'd1 << $urandom_range(0, 63));
          send_item(fdc_pkg::KIND_VALIDATE, held_f[idx], dg, $urandom_range(0, 4) == 0);
        end else if (roll < 92) begin
          f = next_f + frame_t'($urandom_range(0, 40)) - frame_t'(10);
          send_item(fdc_pkg::KIND_QUERY, f, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else if (roll < 99) begin
          send_item(fdc_pkg::KIND_VALIDATE, next_f + frame_t'($urandom_range(100, 1000)),
                    {$urandom, $urandom}, 1'($urandom_range(0, 1)));
        end else begin
          send_item(fdc_pkg::KIND_CLEAR, next_f, {$urandom, $urandom},
                    1'($urandom_range(0, 1)));
          held_f.delete();
          held_d.delete();
        end
      end
    end
    wait_for_results();
  endtask

  task automatic test_noise_items();
    fdc_pkg::kind_t               k;
    frame_t                       f;
    logic [fdc_pkg::DIGEST_W-1:0] dg;
    program_regs($urandom_range(1, 8), $urandom_range(0, 6));
    for (int n = 0; n < 200; n++) begin
      k = fdc_pkg::kind_t'($urandom_range(0, 3));
      if (k == fdc_pkg::KIND_CLEAR && $urandom_range(0, 3) != 0) k = fdc_pkg::KIND_QUERY;
      case ($urandom_range(0, 3))
        0: f = frame_t'($urandom);
        1: f = FRAME_MAX - frame_t'($urandom_range(0, 3));
        2: f = FRAME_FLOOR + frame_t'($urandom_range(0, 3));
        default: f = frame_t'($urandom_range(0, 8)) - frame_t'(4);
      endcase
      dg = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 3));
      send_item(k, f, dg, 1'($urandom_range(0, 1)));
    end
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_lookup();
    test_capacity_limits();
    test_prediction_sessions();
    test_noise_items();
    $display("stores, validates, queries and clears: %0d beats in, %0d results checked",
             items_sent, results_checked);
    $display("%0d register writes across capacity 1..64 and windows 0..max, %0d mismatches",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
